/* src/usd_pkg.sv */
`timescale 1ns / 1ps
// shared types for the udp stream chunk deframer
// no dependencies

package usd_pkg;

    // parse phase, one-hot
    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_PAY  = 3'b100
    } phase_t;

    // varint size prefixes (top two bits of the first byte)
    localparam logic [1:0] VI_PFX_1 = 2'd0;
    localparam logic [1:0] VI_PFX_2 = 2'd1;
    localparam logic [1:0] VI_PFX_4 = 2'd2;
    localparam logic [1:0] VI_PFX_8 = 2'd3;

    // one parser step outcome
    typedef struct packed {
        logic       hit;
        logic [7:0] data;
        logic       first;
        logic       last;
    } res_t;

endpackage

/* src/usd_parser.sv */
`timescale 1ns / 1ps
// chunk parse state: type varint, length varint, payload countdown
// depends on usd_pkg

module usd_parser
    import usd_pkg::*;
#(
    parameter int LENGTH_BITS = 62
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_in,
    output res_t       res
);

    localparam logic [LENGTH_BITS-1:0] ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    phase_t                 phase_reg, phase_next;
    logic [2:0]             left_reg, left_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic                   skip_reg, skip_next;
    logic [LENGTH_BITS-1:0] payload_left_reg, payload_left_next;
    logic                   at_first_reg, at_first_next;

    // varint feed
    logic [2:0]             feed_left;
    logic [LENGTH_BITS-1:0] feed_acc;
    logic                   feed_ovf;
    logic                   feed_done;
    logic [LENGTH_BITS-1:0] len_val;
    logic                   pay_last;

    always_comb
    begin
        if (left_reg == 3'd0)
        begin
            case (data_in[7:6])
                VI_PFX_1: feed_left = 3'd0;
                VI_PFX_2: feed_left = 3'd1;
                VI_PFX_4: feed_left = 3'd3;
                VI_PFX_8: feed_left = 3'd7;
                default:  feed_left = 3'd0;
            endcase
            feed_acc = {{(LENGTH_BITS-6){1'b0}}, data_in[5:0]};
            feed_ovf = 1'b0;
        end
        else
        begin
            feed_left = left_reg - 3'd1;
            feed_acc  = {acc_reg[LENGTH_BITS-9:0], data_in};
            // bits shifted past the length width saturate the value
            feed_ovf  = ovf_reg | (acc_reg[LENGTH_BITS-1:LENGTH_BITS-8] != 8'd0);
        end
        feed_done = (feed_left == 3'd0);
        len_val   = feed_ovf ? {LENGTH_BITS{1'b1}} : feed_acc;
        pay_last  = (payload_left_reg == ONE);
    end

    always_comb
    begin
        phase_next        = phase_reg;
        left_next         = left_reg;
        acc_next          = acc_reg;
        ovf_next          = ovf_reg;
        skip_next         = skip_reg;
        payload_left_next = payload_left_reg;
        at_first_next     = at_first_reg;
        res.hit           = 1'b0;
        res.data          = data_in;
        res.first         = at_first_reg;
        res.last          = pay_last;
        if (step)
        begin
            case (phase_reg)
                PH_PAY:
                begin
                    payload_left_next = payload_left_reg - ONE;
                    res.hit           = ~skip_reg;
                    at_first_next     = 1'b0;
                    if (pay_last)
                        phase_next = PH_TYPE;
                end
                PH_LEN:
                begin
                    left_next = feed_left;
                    acc_next  = feed_acc;
                    ovf_next  = feed_ovf;
                    if (feed_done)
                    begin
                        // zero-length chunk is dropped
                        if (len_val == '0)
                            phase_next = PH_TYPE;
                        else
                        begin
                            payload_left_next = len_val;
                            at_first_next     = 1'b1;
                            phase_next        = PH_PAY;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                    left_next  = feed_left;
                    acc_next   = feed_acc;
                    ovf_next   = feed_ovf;
                    if (feed_done)
                    begin
                        skip_next  = feed_ovf | (feed_acc != '0);
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TYPE;
            left_reg         <= 3'd0;
            acc_reg          <= '0;
            ovf_reg          <= 1'b0;
            skip_reg         <= 1'b0;
            payload_left_reg <= '0;
            at_first_reg     <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            left_reg         <= left_next;
            acc_reg          <= acc_next;
            ovf_reg          <= ovf_next;
            skip_reg         <= skip_next;
            payload_left_reg <= payload_left_next;
            at_first_reg     <= at_first_next;
        end
    end

    a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY |-> payload_left_reg != '0)
        else $error("payload phase with zero bytes left");

    a_hit_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res.hit |-> step && phase_reg == PH_PAY && !skip_reg)
        else $error("result outside a kept payload byte");

    a_last_ends_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PAY && pay_last |=> phase_reg == PH_TYPE)
        else $error("last payload byte did not return to type phase");

endmodule

/* src/udp_stream_chunk_deframer_unit.sv */
`timescale 1ns / 1ps
// top level of the udp stream chunk deframer: input register, parser, result register
// depends on usd_pkg and usd_parser
//
//  channel | signals                             | direction
//  --------+-------------------------------------+----------
//  in      | in_valid, in_stall, in_byte         | into block
//  out     | out_valid, out_stall, out_byte,     | out of block
//          | out_first, out_last                 |
//
// one byte per cycle sustained while out_stall is low; a byte held in the input register passes
// through the parser update into the result register, from which it leaves once taken
// the parse state updates once per byte in a single pass, which sets the rate
// rst_n clears all parse state asynchronously; the block expects a type varint next
// a stalled result holds the output; one more byte still enters the input register,
// after that in_stall rises until the result is taken

module udp_stream_chunk_deframer_unit
    import usd_pkg::*;
#(
    parameter int LENGTH_BITS = 62
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_first,
    output logic       out_last
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_first_reg;
    logic       out_last_reg;

    logic advance;
    logic in_take;
    res_t res;

    // the held byte moves on when the result register is free or being drained
    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    usd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .data_in (in_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && res.hit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= in_byte;
        if (advance && res.hit)
        begin
            out_byte_reg  <= res.data;
            out_first_reg <= res.first;
            out_last_reg  <= res.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_first = out_first_reg;
    assign out_last  = out_last_reg;

    // a full input register behind a stalled result must hold off the source
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && out_stall |-> in_stall)
        else $error("input accepted over a blocked input register");

    // a new result needs a held byte the cycle before
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg && !(out_valid_reg && out_stall) |=> !out_valid_reg)
        else $error("result without a transaction");

    // the input register drains when nothing new comes in
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_stall && !in_valid |=> !in_valid_reg)
        else $error("input register did not drain");

endmodule
